// ===== sv/wem_pkg.sv =====
// Shared types and constants for the wheel encoder and motor interface.
package wem_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int DELTA_BITS = 16;
   localparam int HOLDOFF_BITS = 16;
   localparam int WINDOW_BITS = 8;
   localparam int TIME_BITS = 32;
   localparam int DUTY_BITS = 8;
   localparam int DIR_BITS = 2;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 56;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_RESET = 16'd100;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 8'd10;

   localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_FWD = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_BWD = 2'd2;

   localparam logic CSR_HOLDOFF = 1'b0;
   localparam logic CSR_WINDOW = 1'b1;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_EDGE = 2'd1,
      KIND_DRIVE = 2'd2,
      KIND_READ = 2'd3
   } wem_kind_type;

   // Per-wheel strobes, already qualified by an accepted request.
   typedef struct packed {
      logic edge_en;
      logic close_en;
      logic drive_en;
      logic read_en;
   } wem_ctl_type;

   // Per-wheel view for the result: drive levels after this request, delta before clear.
   typedef struct packed {
      logic fwd;
      logic bwd;
      logic [DUTY_BITS-1:0] duty;
      logic [DELTA_BITS-1:0] delta;
   } wem_stat_type;

endpackage

// ===== sv/wem_wheel.sv =====
// One wheel: edge qualification, window and read counts, direction tracking, drive levels.
module wem_wheel #(
   parameter int COUNT_BITS = wem_pkg::COUNT_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  wem_pkg::wem_ctl_type ctl,
   input  logic [wem_pkg::TIME_BITS-1:0] time_us,
   input  logic pin_high,
   input  logic [wem_pkg::HOLDOFF_BITS-1:0] holdoff_us,
   input  logic [wem_pkg::DIR_BITS-1:0] dir,
   input  logic [wem_pkg::DUTY_BITS-1:0] power,
   output wem_pkg::wem_stat_type stat
);
   import wem_pkg::*;

   localparam int LOW_BITS = (COUNT_BITS < DELTA_BITS) ? COUNT_BITS : DELTA_BITS;
   localparam logic [COUNT_BITS-1:0] LOW_MASK =
      (COUNT_BITS'(1) << LOW_BITS) - COUNT_BITS'(1);

   logic [COUNT_BITS-1:0] win_cnt_ff, win_cnt_in;
   logic [COUNT_BITS-1:0] prev_cnt_ff, prev_cnt_in;
   logic [COUNT_BITS-1:0] read_cnt_ff, read_cnt_in;
   logic [TIME_BITS-1:0] last_edge_ff, last_edge_in;
   logic [DIR_BITS-1:0] cmd_dir_ff, cmd_dir_in;
   logic [DIR_BITS-1:0] rep_dir_ff, rep_dir_in;
   logic fwd_ff, fwd_in;
   logic bwd_ff, bwd_in;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;

   logic [TIME_BITS-1:0] gap;
   logic hit;
   logic take_cmd;
   logic [COUNT_BITS+DELTA_BITS-1:0] read_ext;
   logic [DELTA_BITS-1:0] read_low;

   assign gap = time_us - last_edge_ff;
   assign hit = ctl.edge_en && pin_high &&
                (gap > {{(TIME_BITS-HOLDOFF_BITS){1'b0}}, holdoff_us});
   assign take_cmd = (cmd_dir_ff != rep_dir_ff) &&
                     (((cmd_dir_ff == DIR_STOP) && (win_cnt_ff == '0)) ||
                      (win_cnt_ff > prev_cnt_ff));

   assign read_ext = {{DELTA_BITS{1'b0}}, read_cnt_ff};
   assign read_low = read_ext[DELTA_BITS-1:0];

   always_comb begin
      win_cnt_in = win_cnt_ff;
      prev_cnt_in = prev_cnt_ff;
      read_cnt_in = read_cnt_ff;
      last_edge_in = last_edge_ff;
      cmd_dir_in = cmd_dir_ff;
      rep_dir_in = rep_dir_ff;
      fwd_in = fwd_ff;
      bwd_in = bwd_ff;
      duty_in = duty_ff;
      if (hit) begin
         win_cnt_in = win_cnt_ff + COUNT_BITS'(1);
         read_cnt_in = read_cnt_ff + COUNT_BITS'(1);
         last_edge_in = time_us;
      end
      if (ctl.close_en) begin
         win_cnt_in = '0;
         prev_cnt_in = win_cnt_ff;
         if (take_cmd) begin
            rep_dir_in = cmd_dir_ff;
         end
      end
      if (ctl.drive_en) begin
         cmd_dir_in = dir;
         unique case (dir)
            DIR_FWD: begin
               fwd_in = 1'b1;
               bwd_in = 1'b0;
               duty_in = power;
            end
            DIR_BWD: begin
               fwd_in = 1'b0;
               bwd_in = 1'b1;
               duty_in = power;
            end
            default: begin
               fwd_in = 1'b0;
               bwd_in = 1'b0;
               duty_in = '0;
            end
         endcase
      end
      // drop the low delta bits, keep any wider part of the count
      if (ctl.read_en) begin
         read_cnt_in = read_cnt_ff & ~LOW_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cnt_ff <= '0;
         prev_cnt_ff <= '0;
         read_cnt_ff <= '0;
         last_edge_ff <= '0;
         cmd_dir_ff <= DIR_STOP;
         rep_dir_ff <= DIR_STOP;
         fwd_ff <= 1'b0;
         bwd_ff <= 1'b0;
         duty_ff <= '0;
      end else begin
         win_cnt_ff <= win_cnt_in;
         prev_cnt_ff <= prev_cnt_in;
         read_cnt_ff <= read_cnt_in;
         last_edge_ff <= last_edge_in;
         cmd_dir_ff <= cmd_dir_in;
         rep_dir_ff <= rep_dir_in;
         fwd_ff <= fwd_in;
         bwd_ff <= bwd_in;
         duty_ff <= duty_in;
      end
   end

   always_comb begin
      stat.fwd = fwd_in;
      stat.bwd = bwd_in;
      stat.duty = duty_in;
      stat.delta = (rep_dir_ff == DIR_BWD) ? (DELTA_BITS'(0) - read_low) : read_low;
   end

endmodule

// ===== sv/wheel_encoder_motor_interface_core.sv =====
// Two-wheel encoder counter and H-bridge drive interface, top level.
// Each request (tick, encoder edge, drive command or count read) is taken
// and its single response appears in the one response register on the next
// cycle; a new request is accepted every cycle while the response register
// is empty or being drained, so throughput is one request per clock unless
// the response register stalls. Configuration writes (holdoff in
// microseconds, window length in milliseconds) are always ready and take
// effect on the next request.
module wheel_encoder_motor_interface_core #(
   parameter int COUNT_BITS = wem_pkg::COUNT_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // time_us[31:0], wheel[32], pin_high[33], left_dir[35:34], left_power[43:36],
   // right_dir[45:44], right_power[53:46], zero[55:54]
   input  logic [wem_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // left_fwd[0], left_bwd[1], left_duty[9:2], right_fwd[10], right_bwd[11],
   // right_duty[19:12], left_delta[35:20], right_delta[51:36], zero[55:52]
   output logic [wem_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // delta_valid[0]
   output logic rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [wem_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import wem_pkg::*;

   logic [HOLDOFF_BITS-1:0] holdoff_ff, holdoff_in;
   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [WINDOW_BITS-1:0] ms_ff, ms_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   logic accept;
   wem_kind_type kind;
   logic [TIME_BITS-1:0] time_us;
   logic wheel;
   logic pin_high;
   logic [DIR_BITS-1:0] left_dir, right_dir;
   logic [DUTY_BITS-1:0] left_power, right_power;
   logic [WINDOW_BITS:0] ms_next;
   logic close_win;
   wem_ctl_type ctl_l, ctl_r;
   wem_stat_type stat_l, stat_r;
   logic is_read;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign kind = wem_kind_type'(req_tuser);
   assign time_us = req_tdata[31:0];
   assign wheel = req_tdata[32];
   assign pin_high = req_tdata[33];
   assign left_dir = req_tdata[35:34];
   assign left_power = req_tdata[43:36];
   assign right_dir = req_tdata[45:44];
   assign right_power = req_tdata[53:46];

   assign ms_next = {1'b0, ms_ff} + (WINDOW_BITS+1)'(1);
   assign close_win = accept && (kind == KIND_TICK) && (ms_next > {1'b0, window_ff});
   assign is_read = (kind == KIND_READ);

   always_comb begin
      ctl_l.edge_en = accept && (kind == KIND_EDGE) && !wheel;
      ctl_l.close_en = close_win;
      ctl_l.drive_en = accept && (kind == KIND_DRIVE);
      ctl_l.read_en = accept && is_read;
      ctl_r.edge_en = accept && (kind == KIND_EDGE) && wheel;
      ctl_r.close_en = close_win;
      ctl_r.drive_en = accept && (kind == KIND_DRIVE);
      ctl_r.read_en = accept && is_read;
   end

   wem_wheel #(.COUNT_BITS(COUNT_BITS)) u_left (
      .clock(clock),
      .reset(reset),
      .ctl(ctl_l),
      .time_us(time_us),
      .pin_high(pin_high),
      .holdoff_us(holdoff_ff),
      .dir(left_dir),
      .power(left_power),
      .stat(stat_l)
   );

   wem_wheel #(.COUNT_BITS(COUNT_BITS)) u_right (
      .clock(clock),
      .reset(reset),
      .ctl(ctl_r),
      .time_us(time_us),
      .pin_high(pin_high),
      .holdoff_us(holdoff_ff),
      .dir(right_dir),
      .power(right_power),
      .stat(stat_r)
   );

   always_comb begin
      holdoff_in = holdoff_ff;
      window_in = window_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLDOFF: holdoff_in = csr_data;
            CSR_WINDOW:  window_in = csr_data[WINDOW_BITS-1:0];
            default:     holdoff_in = holdoff_ff;
         endcase
      end
   end

   always_comb begin
      ms_in = ms_ff;
      if (accept && (kind == KIND_TICK)) begin
         // restart the window on close, else advance
         ms_in = close_win ? '0 : ms_next[WINDOW_BITS-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_user_in = is_read;
         rsp_data_in = {4'b0,
                        is_read ? stat_r.delta : DELTA_BITS'(0),
                        is_read ? stat_l.delta : DELTA_BITS'(0),
                        stat_r.duty, stat_r.bwd, stat_r.fwd,
                        stat_l.duty, stat_l.bwd, stat_l.fwd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff <= HOLDOFF_RESET;
         window_ff <= WINDOW_RESET;
         ms_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         holdoff_ff <= holdoff_in;
         window_ff <= window_in;
         ms_ff <= ms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== sv/wem_checker.sv =====
// Port-level checks for the wheel encoder and motor interface, bound to the top level.
module wem_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [wem_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic [1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [wem_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic rsp_tuser,
   input logic csr_valid,
   input logic csr_ready,
   input logic csr_index,
   input logic [wem_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import wem_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // every accepted request yields a response next cycle, flagged only for reads
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=>
         rsp_tvalid && (rsp_tuser == ($past(req_tuser) == KIND_READ)))
      else $error("response missing or wrongly flagged");

   a_bridge_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]) && !(rsp_tdata[10] && rsp_tdata[11]))
      else $error("forward and backward both enabled");

   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[1] || rsp_tdata[9:2] == '0) &&
                     (rsp_tdata[10] || rsp_tdata[11] || rsp_tdata[19:12] == '0))
      else $error("stopped wheel has nonzero duty");

   a_no_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[51:20] == '0)
      else $error("delta on a non-read response");

endmodule

bind wheel_encoder_motor_interface_core wem_checker u_wem_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wheel encoder and motor interface core.
module tb_top;
   import wem_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int CNT_W = COUNT_BITS_DEFAULT;
   // Code 3 stops the motor like DIR_STOP but follows the count-rise rule at window close.
   localparam logic [DIR_BITS-1:0] DIR_COAST = 2'd3;

   typedef struct {
      wem_kind_type kind;
      logic [TIME_BITS-1:0] time_us;
      logic wheel;
      logic pin;
      logic [DIR_BITS-1:0] ldir;
      logic [DUTY_BITS-1:0] lpow;
      logic [DIR_BITS-1:0] rdir;
      logic [DUTY_BITS-1:0] rpow;
   } wheel_req_type;

   typedef struct {
      logic lf;
      logic lb;
      logic [DUTY_BITS-1:0] ld;
      logic rf;
      logic rb;
      logic [DUTY_BITS-1:0] rd;
      logic dv;
      logic [DELTA_BITS-1:0] ldelta;
      logic [DELTA_BITS-1:0] rdelta;
   } wheel_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // Predicted block state and settings.
   logic [HOLDOFF_BITS-1:0] holdoff;
   logic [WINDOW_BITS-1:0] window_len;
   logic [WINDOW_BITS-1:0] ms_elapsed;
   logic [CNT_W-1:0] win_cnt [0:1];
   logic [CNT_W-1:0] prev_win_cnt [0:1];
   logic [CNT_W-1:0] read_cnt [0:1];
   logic [TIME_BITS-1:0] last_enc_us [0:1];
   logic [DIR_BITS-1:0] cmd_dir [0:1];
   logic [DIR_BITS-1:0] rep_dir [0:1];
   logic drv_fwd [0:1];
   logic drv_bwd [0:1];
   logic [DUTY_BITS-1:0] drv_duty [0:1];

   wheel_status_type pending_status [$];
   logic [TIME_BITS-1:0] now_us;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int cycles = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int counted_edges = 0;
   int window_closes = 0;
   int reads_done = 0;
   int dir_changes = 0;

   wheel_encoder_motor_interface_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_status.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic reset_model();
      int w;
      holdoff = HOLDOFF_RESET;
      window_len = WINDOW_RESET;
      ms_elapsed = '0;
      for (w = 0; w < 2; w++) begin
         win_cnt[w] = '0;
         prev_win_cnt[w] = '0;
         read_cnt[w] = '0;
         last_enc_us[w] = '0;
         cmd_dir[w] = DIR_STOP;
         rep_dir[w] = DIR_STOP;
         drv_fwd[w] = 1'b0;
         drv_bwd[w] = 1'b0;
         drv_duty[w] = '0;
      end
   endtask

   task automatic predict_wheel_status(input wheel_req_type it);
      wheel_status_type s;
      logic [WINDOW_BITS:0] next_ms;
      logic [CNT_W-1:0] c;
      logic [CNT_W-1:0] p;
      logic [DIR_BITS-1:0] dir;
      logic [DUTY_BITS-1:0] pwr;
      logic [DELTA_BITS-1:0] delta [0:1];
      logic [TIME_BITS-1:0] gap;
      int w;
      delta[0] = '0;
      delta[1] = '0;
      s.dv = 1'b0;
      case (it.kind)
         KIND_TICK: begin
            next_ms = {1'b0, ms_elapsed} + (WINDOW_BITS+1)'(1);
            if (next_ms > {1'b0, window_len}) begin
               for (w = 0; w < 2; w++) begin
                  c = win_cnt[w];
                  p = prev_win_cnt[w];
                  win_cnt[w] = '0;
                  prev_win_cnt[w] = c;
                  if (cmd_dir[w] != rep_dir[w] &&
                      ((cmd_dir[w] == DIR_STOP && c == '0) || c > p)) begin
                     rep_dir[w] = cmd_dir[w];
                     dir_changes++;
                  end
               end
               ms_elapsed = '0;
               window_closes++;
            end else begin
               ms_elapsed = next_ms[WINDOW_BITS-1:0];
            end
         end
         KIND_EDGE: begin
            gap = it.time_us - last_enc_us[it.wheel];
            if (it.pin && gap > holdoff) begin
               win_cnt[it.wheel] = win_cnt[it.wheel] + CNT_W'(1);
               read_cnt[it.wheel] = read_cnt[it.wheel] + CNT_W'(1);
               last_enc_us[it.wheel] = it.time_us;
               counted_edges++;
            end
         end
         KIND_DRIVE: begin
            for (w = 0; w < 2; w++) begin
               dir = (w == 0) ? it.ldir : it.rdir;
               pwr = (w == 0) ? it.lpow : it.rpow;
               case (dir)
                  DIR_FWD: begin
                     drv_fwd[w] = 1'b1;
                     drv_bwd[w] = 1'b0;
                     drv_duty[w] = pwr;
                  end
                  DIR_BWD: begin
                     drv_fwd[w] = 1'b0;
                     drv_bwd[w] = 1'b1;
                     drv_duty[w] = pwr;
                  end
                  default: begin
                     drv_fwd[w] = 1'b0;
                     drv_bwd[w] = 1'b0;
                     drv_duty[w] = '0;
                  end
               endcase
               cmd_dir[w] = dir;
            end
         end
         KIND_READ: begin
            s.dv = 1'b1;
            for (w = 0; w < 2; w++) begin
               delta[w] = read_cnt[w][DELTA_BITS-1:0];
               if (rep_dir[w] == DIR_BWD)
                  delta[w] = '0 - delta[w];
               read_cnt[w][DELTA_BITS-1:0] = '0;
            end
            reads_done++;
         end
      endcase
      s.lf = drv_fwd[0];
      s.lb = drv_bwd[0];
      s.ld = drv_duty[0];
      s.rf = drv_fwd[1];
      s.rb = drv_bwd[1];
      s.rd = drv_duty[1];
      s.ldelta = delta[0];
      s.rdelta = delta[1];
      pending_status.push_back(s);
   endtask

   task automatic check_field(input string name, input logic [15:0] expv,
                              input logic [15:0] actv);
      if (actv !== expv) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, expv, actv);
      end
   endtask

   always @(posedge clock) begin : check_responses
      wheel_status_type exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (pending_status.size() == 0) begin
            errors++;
            $display("%0t: response %h/%b with nothing expected", $time, rsp_tdata, rsp_tuser);
         end else begin
            exp_s = pending_status.pop_front();
            check_field("left_fwd", exp_s.lf, rsp_tdata[0]);
            check_field("left_bwd", exp_s.lb, rsp_tdata[1]);
            check_field("left_duty", exp_s.ld, rsp_tdata[9:2]);
            check_field("right_fwd", exp_s.rf, rsp_tdata[10]);
            check_field("right_bwd", exp_s.rb, rsp_tdata[11]);
            check_field("right_duty", exp_s.rd, rsp_tdata[19:12]);
            check_field("delta_valid", exp_s.dv, rsp_tuser);
            check_field("left_delta", exp_s.ldelta, rsp_tdata[35:20]);
            check_field("right_delta", exp_s.rdelta, rsp_tdata[51:36]);
         end
      end
   end

   // Enter and leave on a falling edge; hold valid high across back-to-back requests.
   task automatic send_request(input wheel_req_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {2'b00, it.rpow, it.rdir, it.lpow, it.ldir, it.pin, it.wheel, it.time_us};
      do @(posedge clock); while (!req_tready);
      predict_wheel_status(it);
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic wheel_req_type random_request();
      wheel_req_type it;
      it.kind = wem_kind_type'($urandom_range(3));
      it.time_us = $urandom;
      it.wheel = 1'($urandom_range(1));
      it.pin = 1'($urandom_range(1));
      it.ldir = DIR_BITS'($urandom_range(3));
      it.lpow = DUTY_BITS'($urandom_range(255));
      it.rdir = DIR_BITS'($urandom_range(3));
      it.rpow = DUTY_BITS'($urandom_range(255));
      return it;
   endfunction

   task automatic send_kind(input wem_kind_type kind);
      wheel_req_type it;
      it = random_request();
      it.kind = kind;
      send_request(it);
   endtask

   task automatic send_encoder(input logic wheel, input logic pin,
                               input logic [TIME_BITS-1:0] t);
      wheel_req_type it;
      it = random_request();
      it.kind = KIND_EDGE;
      it.wheel = wheel;
      it.pin = pin;
      it.time_us = t;
      send_request(it);
   endtask

   task automatic send_drive(input logic [DIR_BITS-1:0] ld, input logic [DUTY_BITS-1:0] lp,
                             input logic [DIR_BITS-1:0] rd, input logic [DUTY_BITS-1:0] rp);
      wheel_req_type it;
      it = random_request();
      it.kind = KIND_DRIVE;
      it.ldir = ld;
      it.lpow = lp;
      it.rdir = rd;
      it.rpow = rp;
      send_request(it);
   endtask

   // Drop valid and let every outstanding response drain.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_HOLDOFF)
         holdoff = value;
      else
         window_len = value[WINDOW_BITS-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_reset_read();
      send_kind(KIND_READ);
   endtask

   task automatic test_drive_codes();
      send_drive(DIR_FWD, 8'hFF, DIR_BWD, 8'hFF);
      send_drive(DIR_BWD, 8'h00, DIR_FWD, 8'h00);
      send_drive(DIR_COAST, 8'hAA, DIR_STOP, 8'h55);
   endtask

   // Pin low, exactly at holdoff, just past it, and a timestamp wrap.
   task automatic test_encoder_filter();
      send_encoder(1'b0, 1'b0, 32'd1000);
      send_encoder(1'b0, 1'b1, 32'd100);
      send_encoder(1'b0, 1'b1, 32'd101);
      send_encoder(1'b0, 1'b1, 32'd150);
      send_encoder(1'b1, 1'b1, 32'hFFFF_FFFF);
      send_encoder(1'b1, 1'b1, 32'h0000_0063);
      send_encoder(1'b1, 1'b1, 32'h0000_0064);
      send_kind(KIND_READ);
   endtask

   task automatic test_window_close();
      wait_idle();
      csr_write(CSR_WINDOW, {8'hA5, 8'd1});
      send_drive(DIR_BWD, 8'd200, DIR_FWD, 8'd50);
      send_encoder(1'b0, 1'b1, 32'd1000);
      send_encoder(1'b1, 1'b1, 32'd1000);
      send_kind(KIND_TICK);
      send_kind(KIND_TICK);
      send_encoder(1'b0, 1'b1, 32'd2000);
      send_kind(KIND_READ);
      send_drive(DIR_STOP, 8'd9, DIR_COAST, 8'd9);
      repeat (4) send_kind(KIND_TICK);
   endtask

   // Zero length closes on every tick; a lowered length closes on the next tick.
   task automatic test_window_limits();
      wait_idle();
      csr_write(CSR_WINDOW, 16'h0000);
      send_kind(KIND_TICK);
      wait_idle();
      csr_write(CSR_WINDOW, 16'h00FF);
      repeat (4) send_kind(KIND_TICK);
      wait_idle();
      csr_write(CSR_WINDOW, 16'h5A02);
      send_kind(KIND_TICK);
   endtask

   task automatic test_holdoff_limits();
      wait_idle();
      csr_write(CSR_HOLDOFF, 16'h0000);
      send_encoder(1'b0, 1'b1, 32'd5000);
      send_encoder(1'b0, 1'b1, 32'd5000);
      wait_idle();
      csr_write(CSR_HOLDOFF, 16'hFFFF);
      send_encoder(1'b0, 1'b1, 32'd70535);
      send_encoder(1'b0, 1'b1, 32'd70536);
      send_kind(KIND_READ);
   endtask

   // Bursts open with a drive command and carry ticks, in-order edges and reads,
   // with a few fully random requests mixed in.
   task automatic test_random_traffic(input int idle_pct, input int stall,
                                      input logic [HOLDOFF_BITS-1:0] hold,
                                      input logic [WINDOW_BITS-1:0] win, input int n_items);
      wheel_req_type it;
      int sent;
      int burst_len;
      int tick_w;
      int enc_w;
      int left_bias;
      int r;
      wait_idle();
      sender_idle_pct = idle_pct;
      stall_pct = stall;
      csr_write(CSR_HOLDOFF, hold);
      csr_write(CSR_WINDOW, {8'($urandom), win});
      now_us = $urandom;
      sent = 0;
      while (sent < n_items) begin
         burst_len = $urandom_range(60, 15);
         tick_w = $urandom_range(35, 10);
         enc_w = $urandom_range(50, 10);
         left_bias = $urandom_range(90, 10);
         send_drive(DIR_BITS'($urandom_range(3)), DUTY_BITS'($urandom_range(255)),
                    DIR_BITS'($urandom_range(3)), DUTY_BITS'($urandom_range(255)));
         sent++;
         repeat (burst_len) begin
            r = $urandom_range(99);
            it = random_request();
            if (r < tick_w) begin
               it.kind = KIND_TICK;
            end else if (r < tick_w + enc_w) begin
               now_us = now_us + $urandom_range(2 * int'(hold) + 2, int'(hold) / 2);
               it.kind = KIND_EDGE;
               it.time_us = now_us;
               it.wheel = ($urandom_range(99) >= left_bias);
               it.pin = ($urandom_range(9) != 0);
            end else if (r < 92) begin
               it.kind = KIND_READ;
            end
            send_request(it);
            sent++;
         end
      end
   endtask

   initial begin
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_read();
      test_drive_codes();
      test_encoder_filter();
      test_window_close();
      test_window_limits();
      test_holdoff_limits();
      test_random_traffic(0, 0, 16'd100, 8'd10, 425);
      test_random_traffic(56, 0, 16'd0, 8'd2, 425);
      test_random_traffic(0, 56, 16'hFFFF, 8'd4, 425);
      test_random_traffic(36, 36, HOLDOFF_BITS'($urandom_range(500)),
                          WINDOW_BITS'($urandom_range(6, 1)), 425);
      wait_idle();
      $display("Run: %0d requests, %0d responses checked under four idle/stall patterns",
               requests_sent, responses_seen);
      $display("Run: %0d counted edges, %0d window closes, %0d direction updates, %0d reads",
               counted_edges, window_closes, dir_changes, reads_done);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
